// ----- hdl/per_minute_voltage_averager_top_assert.svh -----
// Assertion macros used by the top-level RTL file to check itself.
`ifndef PER_MINUTE_VOLTAGE_AVERAGER_TOP_ASSERT_SVH
`define PER_MINUTE_VOLTAGE_AVERAGER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMVA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pmva_pkg.sv -----
`default_nettype none

package pmva_pkg;

    localparam int TIME_W         = 8;
    localparam int VOLT_W         = 16;
    localparam int BIN_W          = 15;
    localparam int SUM_W          = 24;
    localparam int CNT_W          = 8;
    localparam int MAX_PHASES     = 3;
    localparam int NUM_PHASES_DEF = 3;
    localparam int STEP_W         = 5;
    localparam int BCD_STEPS      = 14;

    localparam logic [CNT_W-1:0]  COUNT_MAX       = 8'hFF;
    localparam logic [SUM_W-1:0]  SUM_MAX         = 24'hFFFFFF;
    localparam logic [VOLT_W-1:0] THREE_WIRE_FILL = 16'hEEEE;
    localparam logic [VOLT_W-1:0] BCD_SAT         = 16'h9999;
    localparam logic [SUM_W-1:0]  BIN_LIMIT       = 24'd9999;

    typedef logic [VOLT_W-1:0] t_volt;

    function automatic logic [BIN_W-1:0] bcd4_to_bin(input t_volt x);
        logic [BIN_W-1:0] d3;
        logic [BIN_W-1:0] d2;
        logic [BIN_W-1:0] d1;
        logic [BIN_W-1:0] d0;
        d3 = BIN_W'(x[15:12]) * BIN_W'(1000);
        d2 = BIN_W'(x[11:8]) * BIN_W'(100);
        d1 = BIN_W'(x[7:4]) * BIN_W'(10);
        d0 = BIN_W'(x[3:0]);
        return d3 + d2 + d1 + d0;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pmva_in_if.sv -----
`default_nettype none

interface pmva_in_if import pmva_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hold_off;
    logic [TIME_W-1:0] second_bcd;
    logic [TIME_W-1:0] minute_bcd;
    logic [VOLT_W-1:0] volt_a_bcd;
    logic [VOLT_W-1:0] volt_b_bcd;
    logic [VOLT_W-1:0] volt_c_bcd;

    modport source (
        output valid, hold_off, second_bcd, minute_bcd, volt_a_bcd, volt_b_bcd, volt_c_bcd,
        input  ready
    );
    modport sink (
        input  valid, hold_off, second_bcd, minute_bcd, volt_a_bcd, volt_b_bcd, volt_c_bcd,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/pmva_out_if.sv -----
`default_nettype none

interface pmva_out_if import pmva_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] avg_a_bcd;
    logic [VOLT_W-1:0] avg_b_bcd;
    logic [VOLT_W-1:0] avg_c_bcd;

    modport source (
        output valid, avg_a_bcd, avg_b_bcd, avg_c_bcd,
        input  ready
    );
    modport sink (
        input  valid, avg_a_bcd, avg_b_bcd, avg_c_bcd,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/pmva_cfg_if.sv -----
`default_nettype none

interface pmva_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/per_minute_voltage_averager_top.sv -----
// Per-minute voltage averager.
// Input channel i_in carries one sample word: hold-off flag, BCD second and
// minute, and three four-digit BCD phase voltages. A word is taken when
// valid and ready are both high; ready is high only while the block is idle.
// A word with hold_off set, or whose second equals the stored second, is
// dropped in the cycle it is taken. Otherwise each phase sum is read from the
// sum memory in the read state, increased and written back in the add state.
// When the minute also changes, a zero is written back instead, and each sum
// is divided by the sample count with a restoring divider and turned into BCD.
// The result word appears on o_out from an output register loaded in the final
// state after the last phase; the next sample word is taken while it waits.
// If the receiver stalls, the result is held, and a second result waits in
// the final state until the register frees up.
// The configuration channel i_cfg writes the three-wire mode bit; it is
// always ready. Reset clears the stored second, minute, count, the mode bit
// and the valid bits of the sum memory, so every sum reads as zero.
`default_nettype none

module per_minute_voltage_averager_top
    import pmva_pkg::*;
#(
    parameter int NUM_PHASES = NUM_PHASES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pmva_in_if.sink    i_in,
    pmva_cfg_if.sink   i_cfg,
    pmva_out_if.source o_out
);

`include "per_minute_voltage_averager_top_assert.svh"

    localparam int IDX_W = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PHASES - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_BCD  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]        r_state;
    logic              r_three_wire;
    logic [TIME_W-1:0] r_last_second;
    logic [TIME_W-1:0] r_last_minute;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_divisor;
    logic              r_min_chg;
    logic              r_emit;
    logic [IDX_W-1:0]  r_idx;
    logic [STEP_W-1:0] r_step;

    logic [SUM_W-1:0]  r_mem [NUM_PHASES];
    logic [NUM_PHASES-1:0] r_sum_vld;
    logic [SUM_W-1:0]  r_rd_data;
    logic              r_rd_vld;

    t_volt             r_volt [NUM_PHASES];
    t_volt             r_avg [NUM_PHASES];
    logic [BIN_W-1:0]  r_bin;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [BCD_STEPS-1:0] r_dd_bin;
    t_volt             r_dd_bcd;

    logic              r_out_vld;
    t_volt             r_out_a;
    t_volt             r_out_b;
    t_volt             r_out_c;

    logic              w_in_acc;
    logic              w_start;
    logic [CNT_W-1:0]  w_count_inc;
    t_volt             w_in_volt [MAX_PHASES];
    t_volt             w_avg_full [MAX_PHASES];
    logic [SUM_W-1:0]  w_old_sum;
    logic [SUM_W:0]    w_add;
    logic [SUM_W-1:0]  w_new_sum;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [SUM_W-1:0]  w_mem_wdata;
    logic [CNT_W:0]    w_trial;
    logic              w_fits;
    t_volt             w_adj;
    logic              w_avg_we;
    t_volt             w_avg_wdata;
    logic              w_out_load;

    logic [2:0]        n_state;
    logic [IDX_W-1:0]  n_idx;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_start     = w_in_acc && !i_in.hold_off && (i_in.second_bcd != r_last_second);
    assign w_count_inc = (r_count != COUNT_MAX) ? r_count + CNT_W'(1) : r_count;

    assign w_in_volt[0] = i_in.volt_a_bcd;
    assign w_in_volt[1] = i_in.volt_b_bcd;
    assign w_in_volt[2] = i_in.volt_c_bcd;

    assign w_old_sum   = r_rd_vld ? r_rd_data : '0;
    assign w_add       = {1'b0, w_old_sum} + (SUM_W + 1)'(r_bin);
    assign w_new_sum   = w_add[SUM_W] ? SUM_MAX : w_add[SUM_W-1:0];
    assign w_mem_re    = (r_state == ST_READ);
    assign w_mem_we    = (r_state == ST_ADD);
    assign w_mem_wdata = r_min_chg ? '0 : w_new_sum;

    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_divisor});

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            w_adj[n*4 +: 4] = (r_dd_bcd[n*4 +: 4] >= 4'd5) ?
                              r_dd_bcd[n*4 +: 4] + 4'd3 : r_dd_bcd[n*4 +: 4];
        end
    end

    assign w_avg_we    = (r_state == ST_BCD) &&
                         ((r_quo > BIN_LIMIT) || (r_step == STEP_W'(BCD_STEPS)));
    assign w_avg_wdata = (r_quo > BIN_LIMIT) ? BCD_SAT : r_dd_bcd;
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_vld || o_out.ready);

    for (genvar p = 0; p < MAX_PHASES; p++) begin : g_phase
        if (p < NUM_PHASES) begin : g_used
            always_ff @(posedge i_clk) begin
                if (w_start) begin
                    r_volt[p] <= w_in_volt[p];
                end
                if (w_avg_we && (r_idx == IDX_W'(p))) begin
                    r_avg[p] <= w_avg_wdata;
                end
            end
            assign w_avg_full[p] = r_avg[p];
        end else begin : g_unused
            assign w_avg_full[p] = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_READ;
                    n_idx   = '0;
                end
            end
            ST_READ: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                priority if (r_min_chg && r_emit) begin
                    n_state = ST_DIV;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                    n_idx   = r_idx + IDX_W'(1);
                end
            end
            ST_DIV: begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = ST_BCD;
                end
            end
            ST_BCD: begin
                if (w_avg_we) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_READ;
                        n_idx   = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_three_wire  <= 1'b0;
            r_last_second <= '0;
            r_last_minute <= '0;
            r_count       <= '0;
            r_min_chg     <= 1'b0;
            r_emit        <= 1'b0;
            r_idx         <= '0;
            r_sum_vld     <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg.valid && i_cfg.ready) begin
                r_three_wire <= i_cfg.data;
            end
            if (w_start) begin
                r_last_second <= i_in.second_bcd;
                if (i_in.minute_bcd != r_last_minute) begin
                    r_last_minute <= i_in.minute_bcd;
                    r_count       <= '0;
                    r_min_chg     <= 1'b1;
                    r_emit        <= (w_count_inc != '0);
                end else begin
                    r_count   <= w_count_inc;
                    r_min_chg <= 1'b0;
                    r_emit    <= 1'b0;
                end
            end
            if (w_mem_we) begin
                r_sum_vld[r_idx] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_idx] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_vld  <= r_sum_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_divisor <= w_count_inc;
        end
        if (r_state == ST_READ) begin
            r_bin <= bcd4_to_bin(r_volt[r_idx]);
        end
        unique case (r_state)
            ST_ADD: begin
                r_quo  <= w_new_sum;
                r_rem  <= '0;
                r_step <= '0;
            end
            ST_DIV: begin
                r_rem  <= w_fits ? CNT_W'(w_trial - {1'b0, r_divisor}) : w_trial[CNT_W-1:0];
                r_quo  <= {r_quo[SUM_W-2:0], w_fits};
                r_step <= (r_step == STEP_W'(SUM_W - 1)) ? '0 : r_step + STEP_W'(1);
                r_dd_bcd <= '0;
                r_dd_bin <= {r_quo[BCD_STEPS-2:0], w_fits};
            end
            ST_BCD: begin
                r_dd_bcd <= {w_adj[VOLT_W-2:0], r_dd_bin[BCD_STEPS-1]};
                r_dd_bin <= {r_dd_bin[BCD_STEPS-2:0], 1'b0};
                r_step   <= r_step + STEP_W'(1);
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_a <= w_avg_full[0];
            r_out_b <= r_three_wire ? THREE_WIRE_FILL : w_avg_full[1];
            r_out_c <= w_avg_full[2];
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.avg_a_bcd = r_out_a;
    assign o_out.avg_b_bcd = r_out_b;
    assign o_out.avg_c_bcd = r_out_c;

    `PMVA_ASSERT_SAME(a_mem_no_overlap, i_clk, i_rst_n, w_mem_we, !w_mem_re,
        "sum memory read and written in the same cycle")
    `PMVA_ASSERT_NEXT(a_start_reads, i_clk, i_rst_n, w_start, r_state == ST_READ,
        "accepted sample did not start a memory read")
    `PMVA_ASSERT_SAME(a_div_nonzero, i_clk, i_rst_n, r_state == ST_DIV,
        r_divisor != '0 && r_emit, "division started with a zero count")
    `PMVA_ASSERT_NEXT(a_stall_waits, i_clk, i_rst_n,
        r_state == ST_DONE && r_out_vld && !o_out.ready, r_state == ST_DONE,
        "result left the final state while the output register was full")

endmodule

`default_nettype wire
